FILE: hw/rtl/spsc_pkg.sv
// Shared types, constants and the sequencer program for the support polygon check.
package spsc_pkg;

	// Default sizes handed to the top level
	localparam int LEG_COUNT_DEF  = 6;
	localparam int COORD_BITS_DEF = 16;

	// Configuration register file
	localparam int HIP_REGS   = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int HIP_W      = 16;
	localparam int CNT_OUT_W  = 3;

	// Sequencer step addresses
	localparam int UPC_W = 3;
	localparam logic [UPC_W-1:0] ST_IDLE = 3'd0;
	localparam logic [UPC_W-1:0] ST_CHK  = 3'd1;
	localparam logic [UPC_W-1:0] ST_RDI  = 3'd2;
	localparam logic [UPC_W-1:0] ST_RDJ  = 3'd3;
	localparam logic [UPC_W-1:0] ST_MUL1 = 3'd4;
	localparam logic [UPC_W-1:0] ST_MUL2 = 3'd5;
	localparam logic [UPC_W-1:0] ST_CMP  = 3'd6;
	localparam logic [UPC_W-1:0] ST_EMIT = 3'd7;

	// Point memory read select
	typedef enum logic [1:0] {
		RD_NONE,
		RD_I,
		RD_J
	} rd_sel_t;

	// Sequencer jump kinds
	typedef enum logic [2:0] {
		JMP_NEXT,   // fall through
		JMP_ACCEPT, // stay until a final beat is taken, then go to target
		JMP_EMPTY,  // go to target when no point is stored
		JMP_LOOP,   // go to target while edges remain, else fall through
		JMP_EMIT    // go to target once the result register is free
	} jmp_t;

	// One control word
	typedef struct packed {
		logic             in_rdy;  // input channel open
		logic             clr;     // clear edge pointer and verdict
		rd_sel_t          rd;      // point memory read
		logic             lat_a;   // hold read data as vertex i
		logic             mul_en;  // load product register
		logic             mul_yx;  // 0: xi*yj, 1: yi*xj
		logic             acc_ld;  // move product to accumulator
		logic             cmp;     // test cross product sign
		jmp_t             jmp;
		logic [UPC_W-1:0] tgt;
	} uword_t;

	// Program: load legs, then walk edges i -> i+1 computing xi*yj - yi*xj
	function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
		uword_t w;
		w = '{in_rdy: 1'b0, clr: 1'b0, rd: RD_NONE, lat_a: 1'b0, mul_en: 1'b0,
			mul_yx: 1'b0, acc_ld: 1'b0, cmp: 1'b0, jmp: JMP_NEXT, tgt: ST_IDLE};
		case (addr)
			ST_IDLE: begin
				w.in_rdy = 1'b1;
				w.jmp    = JMP_ACCEPT;
				w.tgt    = ST_CHK;
			end
			ST_CHK: begin
				w.clr = 1'b1;
				w.jmp = JMP_EMPTY;
				w.tgt = ST_EMIT;
			end
			ST_RDI: begin
				w.rd = RD_I;
			end
			ST_RDJ: begin
				w.rd    = RD_J;
				w.lat_a = 1'b1;
			end
			ST_MUL1: begin
				w.mul_en = 1'b1;
			end
			ST_MUL2: begin
				w.mul_en = 1'b1;
				w.mul_yx = 1'b1;
				w.acc_ld = 1'b1;
			end
			ST_CMP: begin
				w.cmp = 1'b1;
				w.jmp = JMP_LOOP;
				w.tgt = ST_RDI;
			end
			ST_EMIT: begin
				w.jmp = JMP_EMIT;
				w.tgt = ST_IDLE;
			end
			default: begin
				w.jmp = JMP_EMIT;
				w.tgt = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: hw/rtl/support_polygon_stability_check.sv
// Top level: leg collection, point memory and microcoded edge walk for the stability check.
// A leg beat is taken while the sequencer idles; a final beat starts the edge walk, which
// per stored point reads vertex i and its successor, forms both products and tests the
// sign, then emits the result. Throughput: one leg per cycle while loading; the walk pace
// is set by the single memory read port and the one shared multiplier used twice per edge.
// Reset: arst_n clears the hip offsets, counters, sequencer and output valid; the point
// memory is not cleared, only entries below the stored count are ever read.
module support_polygon_stability_check #(
	parameter int LEG_COUNT  = spsc_pkg::LEG_COUNT_DEF,
	parameter int COORD_BITS = spsc_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_wr_en,
	input  logic [spsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spsc_pkg::CFG_DATA_W-1:0]     cfg_data,
	// leg input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_BITS-1:0]        foot_x,
	input  logic signed [COORD_BITS-1:0]        foot_y,
	input  logic                                on_ground,
	input  logic                                final_leg,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                stable,
	output logic [spsc_pkg::CNT_OUT_W-1:0]      support_count
);
	import spsc_pkg::*;

	localparam int CNT_W = $clog2(LEG_COUNT + 1);
	localparam int IDX_W = $clog2(LEG_COUNT);
	localparam int PT_W  = ((COORD_BITS > HIP_W) ? COORD_BITS : HIP_W) + 1;
	localparam int PR_W  = 2 * PT_W;

	// control state
	logic [UPC_W-1:0]         upc_q, upc_d;
	logic [CNT_W-1:0]         leg_cnt_q;
	logic [CNT_W-1:0]         pt_cnt_q;
	logic [CNT_W-1:0]         i_q;
	logic                     unstable_q;
	logic                     out_valid_q;
	logic                     stable_q;
	logic [CNT_OUT_W-1:0]     count_q;
	logic [CFG_DATA_W-1:0]    hip_q [HIP_REGS];

	// datapath
	logic signed [PT_W-1:0]   mem_x [LEG_COUNT];
	logic signed [PT_W-1:0]   mem_y [LEG_COUNT];
	logic signed [PT_W-1:0]   rd_x_q, rd_y_q;
	logic signed [PT_W-1:0]   a_x_q, a_y_q;
	logic signed [PR_W-1:0]   prod_q, acc_q;

	uword_t                   uw;
	logic                     in_acc;
	logic                     out_free;
	logic                     last_edge;
	logic                     append;
	logic [CFG_DATA_W-1:0]    hip_sel;
	logic signed [PT_W-1:0]   new_x, new_y;
	logic [CNT_W-1:0]         rd_ptr;
	logic signed [PT_W-1:0]   op_a, op_b;
	logic signed [PR_W:0]     diff;

	assign uw        = ucode(upc_q);
	assign in_stall  = !uw.in_rdy;
	assign in_acc    = in_valid && uw.in_rdy;
	assign out_free  = !out_valid_q || !out_stall;
	assign last_edge = ((i_q + CNT_W'(1)) == pt_cnt_q);
	assign append    = in_acc && on_ground && (int'(leg_cnt_q) < LEG_COUNT);

	// hip offset of the current leg, zero past the register file
	always_comb begin
		hip_sel = '0;
		for (int k = 0; k < HIP_REGS; k++) begin
			if (int'(leg_cnt_q) == k) hip_sel = hip_q[k];
		end
	end

	// body-frame point of the incoming foot
	assign new_x = {{(PT_W-HIP_W){hip_sel[HIP_W-1]}}, hip_sel[HIP_W-1:0]}
		+ {{(PT_W-COORD_BITS){foot_x[COORD_BITS-1]}}, foot_x};
	assign new_y = {{(PT_W-HIP_W){hip_sel[2*HIP_W-1]}}, hip_sel[2*HIP_W-1:HIP_W]}
		+ {{(PT_W-COORD_BITS){foot_y[COORD_BITS-1]}}, foot_y};

	// read pointer: vertex i or its cyclic successor
	assign rd_ptr = (uw.rd == RD_J) ? (last_edge ? '0 : i_q + CNT_W'(1)) : i_q;

	// multiplier operands and cross product sign test
	assign op_a = uw.mul_yx ? a_y_q : a_x_q;
	assign op_b = uw.mul_yx ? rd_x_q : rd_y_q;
	assign diff = {acc_q[PR_W-1], acc_q} - {prod_q[PR_W-1], prod_q};

	// next step
	always_comb begin
		case (uw.jmp)
			JMP_NEXT:   upc_d = upc_q + UPC_W'(1);
			JMP_ACCEPT: upc_d = (in_acc && final_leg) ? uw.tgt : upc_q;
			JMP_EMPTY:  upc_d = (pt_cnt_q == '0) ? uw.tgt : upc_q + UPC_W'(1);
			JMP_LOOP:   upc_d = last_edge ? upc_q + UPC_W'(1) : uw.tgt;
			JMP_EMIT:   upc_d = out_free ? uw.tgt : upc_q;
			default:    upc_d = ST_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HIP_REGS; k++) hip_q[k] <= '0;
		end else if (cfg_wr_en && (int'(cfg_index) < HIP_REGS)) begin
			hip_q[cfg_index] <= cfg_data;
		end
	end

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= ST_IDLE;
			leg_cnt_q   <= '0;
			pt_cnt_q    <= '0;
			i_q         <= '0;
			unstable_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (in_acc && (int'(leg_cnt_q) < LEG_COUNT)) leg_cnt_q <= leg_cnt_q + CNT_W'(1);
			if (append) pt_cnt_q <= pt_cnt_q + CNT_W'(1);
			if (uw.clr) begin
				i_q        <= '0;
				unstable_q <= 1'b0;
			end else if (uw.jmp == JMP_LOOP && !last_edge) begin
				i_q <= i_q + CNT_W'(1);
			end
			if (uw.cmp && !diff[PR_W] && (diff != '0)) unstable_q <= 1'b1;
			if (uw.jmp == JMP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				leg_cnt_q   <= '0;
				pt_cnt_q    <= '0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (uw.jmp == JMP_EMIT && out_free) begin
			stable_q <= !unstable_q;
			count_q  <= CNT_OUT_W'(pt_cnt_q);
		end
	end

	// point memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (append) begin
			mem_x[pt_cnt_q[IDX_W-1:0]] <= new_x;
			mem_y[pt_cnt_q[IDX_W-1:0]] <= new_y;
		end
		if (uw.rd != RD_NONE) begin
			rd_x_q <= mem_x[rd_ptr[IDX_W-1:0]];
			rd_y_q <= mem_y[rd_ptr[IDX_W-1:0]];
		end
	end

	// vertex hold, product and accumulator
	always_ff @(posedge clk) begin
		if (uw.lat_a) begin
			a_x_q <= rd_x_q;
			a_y_q <= rd_y_q;
		end
		if (uw.mul_en) prod_q <= op_a * op_b;
		if (uw.acc_ld) acc_q <= prod_q;
	end

	assign out_valid     = out_valid_q;
	assign stable        = stable_q;
	assign support_count = count_q;

`ifndef ASSERT_OFF
	// stored points never outnumber legs seen
	a_cnt_order: assert property (@(posedge clk) disable iff (!arst_n)
		pt_cnt_q <= leg_cnt_q)
		else $error("point count exceeds leg count");

	// leg counter saturates at the leg count
	a_leg_sat: assert property (@(posedge clk) disable iff (!arst_n)
		int'(leg_cnt_q) <= LEG_COUNT)
		else $error("leg counter overran");

	// a new result only comes from the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(upc_q) == ST_EMIT)
		else $error("result loaded outside emit step");

	// edge pointer stays inside the stored list during the walk
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == ST_RDI) |-> i_q < pt_cnt_q)
		else $error("edge pointer out of range");
`endif

endmodule

FILE: test/tb.sv
// Testbench for support_polygon_stability_check: random leg poses checked against a scoreboard.
`timescale 1ns / 1ps

// Verdict the block owes for one evaluated pose
typedef struct {
	logic                              stable;
	logic [spsc_pkg::CNT_OUT_W-1:0]    count;
} pose_verdict_t;

// Tracks the leg collection and predicts each pose verdict
class pose_tracker;
	localparam int LEGS = spsc_pkg::LEG_COUNT_DEF;
	localparam int CB   = spsc_pkg::COORD_BITS_DEF;
	localparam int HW   = spsc_pkg::HIP_W;

	logic [spsc_pkg::CFG_DATA_W-1:0] hip [spsc_pkg::HIP_REGS];
	longint        px [LEGS];
	longint        py [LEGS];
	int            n_pts;
	int            leg_idx;
	int            errors;
	pose_verdict_t verdicts_due [$];

	function new();
		foreach (hip[i]) hip[i] = '0;
		n_pts   = 0;
		leg_idx = 0;
		errors  = 0;
	endfunction

	function void set_hip(int idx, logic [spsc_pkg::CFG_DATA_W-1:0] v);
		// indexes past the hip registers are dropped
		if (idx < spsc_pkg::HIP_REGS)
			hip[idx] = v;
	endfunction

	// Walk the stored points cyclically; any positive cross product means unstable
	function bit polygon_holds();
		int     j;
		longint ex, ey, cx, cy;
		for (int i = 0; i < n_pts; i++) begin
			j  = (i + 1 == n_pts) ? 0 : i + 1;
			ex = px[j] - px[i];
			ey = py[j] - py[i];
			cx = -px[i];
			cy = -py[i];
			if (ex * cy - ey * cx > 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function void take_leg(logic signed [CB-1:0] fx, logic signed [CB-1:0] fy,
			logic grounded, logic last);
		longint        hx, hy;
		pose_verdict_t v;
		if (leg_idx < LEGS) begin
			if (grounded) begin
				hx = 0;
				hy = 0;
				if (leg_idx < spsc_pkg::HIP_REGS) begin
					hx = longint'($signed(hip[leg_idx][HW-1:0]));
					hy = longint'($signed(hip[leg_idx][2*HW-1:HW]));
				end
				if (n_pts < LEGS) begin
					px[n_pts] = hx + longint'(fx);
					py[n_pts] = hy + longint'(fy);
					n_pts++;
				end
			end
			leg_idx++;
		end
		// extra legs are ignored but a final mark still evaluates
		if (last) begin
			v.stable = polygon_holds();
			v.count  = n_pts[spsc_pkg::CNT_OUT_W-1:0];
			verdicts_due = {verdicts_due, v};
			n_pts   = 0;
			leg_idx = 0;
		end
	endfunction

	function void check_verdict(logic st, logic [spsc_pkg::CNT_OUT_W-1:0] cnt);
		pose_verdict_t v;
		if (verdicts_due.size() == 0) begin
			$error("result with no pose pending: stable=%0d support_count=%0d", st, cnt);
			errors++;
			return;
		end
		v = verdicts_due.pop_front();
		if (st !== v.stable) begin
			$error("stable: expected %0d, got %0d", v.stable, st);
			errors++;
		end
		if (cnt !== v.count) begin
			$error("support_count: expected %0d, got %0d", v.count, cnt);
			errors++;
		end
	endfunction

	function int pending();
		return verdicts_due.size();
	endfunction
endclass

module tb;
	localparam int LEGS        = spsc_pkg::LEG_COUNT_DEF;
	localparam int CB          = spsc_pkg::COORD_BITS_DEF;
	localparam int LAT_PAD     = 3 + 5 * LEGS + 8;
	localparam int WATCHDOG    = 3000;
	localparam int PHASE_ITEMS = 95;

	typedef enum int {
		HIP_ZERO,
		HIP_CW,
		HIP_CCW,
		HIP_MAX,
		HIP_MIN,
		HIP_MIXED,
		HIP_RAND
	} hip_set_t;

	logic                                clk;
	logic                                arst_n        = 1'b0;
	logic                                cfg_wr_en     = 1'b0;
	logic [spsc_pkg::CFG_IDX_W-1:0]      cfg_index     = '0;
	logic [spsc_pkg::CFG_DATA_W-1:0]     cfg_data      = '0;
	logic                                in_valid      = 1'b0;
	logic                                in_stall;
	logic signed [CB-1:0]                foot_x        = '0;
	logic signed [CB-1:0]                foot_y        = '0;
	logic                                on_ground     = 1'b0;
	logic                                final_leg     = 1'b0;
	logic                                out_valid;
	logic                                out_stall     = 1'b0;
	logic                                stable;
	logic [spsc_pkg::CNT_OUT_W-1:0]      support_count;

	pose_tracker trk;
	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int          quiet_cycles  = 0;

	// hexapod-like hip layout around the center of mass, clockwise in leg order
	int lay_x [6] = '{60, 120, 60, -60, -120, -60};
	int lay_y [6] = '{100, 0, -100, -100, 0, 100};

	support_polygon_stability_check #(
		.LEG_COUNT (LEGS),
		.COORD_BITS(CB)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.foot_x       (foot_x),
		.foot_y       (foot_y),
		.on_ground    (on_ground),
		.final_leg    (final_leg),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.stable       (stable),
		.support_count(support_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// result beats against the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			trk.check_verdict(stable, support_count);
	end

	// watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [31:0] hip_word(hip_set_t set, int leg);
		case (set)
			HIP_ZERO:  return 32'h0;
			HIP_CW:    return {16'(lay_y[leg]), 16'(lay_x[leg])};
			HIP_CCW:   return {16'(-lay_y[leg]), 16'(lay_x[leg])};
			HIP_MAX:   return 32'h7fff_7fff;
			HIP_MIN:   return 32'h8000_8000;
			HIP_MIXED: return leg[0] ? 32'h7fff_8000 : 32'h8000_7fff;
			default:   return $urandom;
		endcase
	endfunction

	// One beat on the leg channel, with random idle cycles ahead of it
	task automatic send_leg(input int fx, input int fy, input bit grounded, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		foot_x    <= fx[CB-1:0];
		foot_y    <= fy[CB-1:0];
		on_ground <= grounded;
		final_leg <= last;
		do @(posedge clk); while (in_stall);
		trk.take_leg(foot_x, foot_y, on_ground, final_leg);
	endtask

	task automatic wait_verdicts();
		in_valid <= 1'b0;
		while (trk.pending() != 0)
			@(posedge clk);
	endtask

	// Idle the block fully: all verdicts in, then let any walk finish
	task automatic drain();
		wait_verdicts();
		repeat (LAT_PAD) @(posedge clk);
	endtask

	task automatic write_hip(input int idx, input logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx[spsc_pkg::CFG_IDX_W-1:0];
		cfg_data  <= v;
		@(posedge clk);
		trk.set_hip(idx, v);
	endtask

	task automatic load_hips(input hip_set_t set, input bit junk);
		for (int leg = 0; leg < spsc_pkg::HIP_REGS; leg++)
			write_hip(leg, hip_word(set, leg));
		// unmapped indexes must leave the hips alone
		if (junk) begin
			write_hip(spsc_pkg::HIP_REGS, $urandom);
			write_hip(spsc_pkg::HIP_REGS + 1, $urandom);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Random pose: mostly full six-leg poses, some short, some with extra legs
	task automatic send_pose(output int legs);
		int  r;
		int  fx, fy;
		bit  near;
		r    = $urandom_range(9);
		near = ($urandom_range(3) != 0);
		if (r < 6)
			legs = LEGS;
		else if (r == 6)
			legs = LEGS + $urandom_range(1, 2);
		else
			legs = $urandom_range(1, LEGS - 1);
		for (int i = 0; i < legs; i++) begin
			if (near) begin
				fx = int'($urandom_range(60)) - 30;
				fy = int'($urandom_range(60)) - 30;
			end else begin
				fx = $urandom;
				fy = $urandom;
			end
			send_leg(fx, fy, $urandom_range(9) < 7, i == legs - 1);
		end
	endtask

	hip_set_t plan [7] = '{HIP_CW, HIP_MAX, HIP_MIN, HIP_RAND, HIP_CCW, HIP_MIXED, HIP_CW};

	initial begin
		int n, legs;
		trk = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed poses with hips at reset value
		// no grounded leg, extreme feet
		send_leg(32767, -32768, 1'b0, 1'b0);
		send_leg(-32768, 32767, 1'b0, 1'b0);
		send_leg(32767, 32767, 1'b0, 1'b0);
		send_leg(-32768, -32768, 1'b0, 1'b0);
		send_leg(0, 0, 1'b0, 1'b0);
		send_leg(-1, -1, 1'b0, 1'b1);
		// single grounded leg marked final at once
		send_leg(500, -700, 1'b1, 1'b1);
		// two legs on a line through the origin
		send_leg(100, 0, 1'b1, 1'b0);
		send_leg(-100, 0, 1'b1, 1'b1);
		// two legs on a line missing the origin
		send_leg(100, 50, 1'b1, 1'b0);
		send_leg(-100, 50, 1'b1, 1'b1);
		// triangle around the origin, clockwise
		send_leg(0, 100, 1'b1, 1'b0);
		send_leg(87, -50, 1'b1, 1'b0);
		send_leg(-87, -50, 1'b1, 1'b1);
		// too many legs, extremes, final mark on an ignored leg
		for (int i = 0; i < LEGS + 2; i++)
			send_leg(i[0] ? -32768 : 32767, i[1] ? 32767 : -32768, 1'b1, i == LEGS + 1);

		// random phases, each loading a hip set from the plan and picking an idle pattern
		for (int p = 0; p < 7; p++) begin
			drain();
			load_hips(plan[p], p == 3);
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 75; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 75; end
				default: begin send_idle_pct = 10; stall_pct = 10; end
			endcase
			n = 0;
			while (n < PHASE_ITEMS) begin
				send_pose(legs);
				n += legs;
				// sender holds off now and then until every verdict is back
				if ($urandom_range(7) == 0)
					wait_verdicts();
			end
		end

		drain();
		if (trk.errors == 0 && trk.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
